@@ rtl/pipf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pipf_pkg
// shared constants, codes and types of the point in polygon filter
// ----------------------------------------------------------------------------
package pipf_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 24;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int VERT_W       = 2 * COORD_W;
  localparam int OP_W         = 2;
  localparam int IN_DATA_W    = 48;
  localparam int OUT_DATA_W   = 56;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEST   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] xi;
    logic [COORD_W-1:0] yi;
    logic [COORD_W-1:0] xj;
    logic [COORD_W-1:0] yj;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } edge_req_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic busy;
  } edge_rsp_t;

endpackage
`default_nettype wire

@@ rtl/point_in_polygon_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_polygon_filter
// even-odd ray crossing test of points against a stored polygon
// ----------------------------------------------------------------------------
// A word carries an opcode in tuser (clear, append vertex, test point) and a
// signed Q15.8 point in tdata. Clear and append are carried out as the word is
// taken. A test of a polygon of n vertices walks the vertex ram, which has one
// read port, reading one vertex a cycle (n + 1 reads, the last vertex first);
// then the ram read and the two stage crossing unit drain, and the verdict is
// loaded into the output register once that is free. A test of an empty
// polygon, like a dropped append, goes straight to the load of the output
// register. A result word holds the verdict and the echoed point; an append
// to a full store returns the dropped vertex with the overflow flag set in
// tuser. One word is worked on at a time; the next word can be taken in the
// cycle the result appears, and a new word is taken while a finished result
// still waits at the output register.
// ----------------------------------------------------------------------------
module point_in_polygon_filter
  import pipf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // px, py
  input  wire logic [OP_W-1:0]       s_tuser,  // opcode
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata,  // inside_res, out_x, out_y, zero pad
  output logic      [0:0]            m_tuser   // overflow
);

  state_t state, state_next;

  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] step;
  logic               rd_vld;
  logic               rd_first;
  logic [VERT_W-1:0]  prev;
  logic [VERT_W-1:0]  rdata;
  logic [COORD_W-1:0] pt_x;
  logic [COORD_W-1:0] pt_y;
  logic               parity;
  logic               res_ovf;

  logic               accept;
  logic               room;
  logic               out_free;
  logic               we;
  logic [ADDR_W-1:0]  raddr;
  logic [COUNT_W-1:0] raddr_full;
  op_t                op;

  edge_req_t req;
  edge_rsp_t rsp;

  assign op       = op_t'(s_tuser);
  assign accept   = s_tvalid && s_tready;
  assign room     = cnt < COUNT_W'(MAX_VERTICES);
  assign out_free = !m_tvalid || m_tready;
  assign we       = accept && (op == OP_APPEND) && room;

  assign raddr_full = (step == '0) ? (cnt - 1'b1) : (step - 1'b1);
  assign raddr      = raddr_full[ADDR_W-1:0];

  pipf_ram #(
    .WIDTH (VERT_W),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cnt[ADDR_W-1:0]),
    .wdata (s_tdata[VERT_W-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    req.valid = rd_vld && !rd_first;
    req.xi    = rdata[COORD_W-1:0];
    req.yi    = rdata[VERT_W-1:COORD_W];
    req.xj    = prev[COORD_W-1:0];
    req.yj    = prev[VERT_W-1:COORD_W];
    req.x     = pt_x;
    req.y     = pt_y;
  end

  pipf_edge u_edge (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (accept) begin
          case (op)
            OP_APPEND: begin
              if (!room) begin
                state_next = ST_DONE;
              end
            end
            OP_TEST: begin
              state_next = (cnt == '0) ? ST_DONE : ST_WALK;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (step == cnt) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !rsp.busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      step     <= '0;
      rd_vld   <= 1'b0;
      rd_first <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld   <= (state == ST_WALK);
      rd_first <= (state == ST_WALK) && (step == '0);
      if (accept) begin
        step <= '0;
        case (op)
          OP_CLEAR: begin
            cnt <= '0;
          end
          OP_APPEND: begin
            if (room) begin
              cnt <= cnt + 1'b1;
            end
          end
          default: begin
            cnt <= cnt;
          end
        endcase
      end else if (state == ST_WALK) begin
        step <= step + 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pt_x    <= s_tdata[COORD_W-1:0];
      pt_y    <= s_tdata[VERT_W-1:COORD_W];
      parity  <= (cnt == '0);
      res_ovf <= (op == OP_APPEND);
    end else if (rsp.valid && rsp.hit) begin
      parity <= ~parity;
    end
    if (rd_vld) begin
      prev <= rdata;
    end
    if (state == ST_DONE && out_free) begin
      m_tdata    <= {(OUT_DATA_W - 1 - VERT_W)'(0), pt_y, pt_x, parity && !res_ovf};
      m_tuser[0] <= res_ovf;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pipf_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pipf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pipf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/pipf_edge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pipf_edge
// two stage edge crossing unit: differences, then cross products and compare
// ----------------------------------------------------------------------------
module pipf_edge
  import pipf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire edge_req_t req,
  output edge_rsp_t      rsp
);

  logic                     v1;
  logic                     straddle1;
  logic                     dy_pos1;
  logic signed [DIFF_W-1:0] dy1;
  logic signed [DIFF_W-1:0] ax1;
  logic signed [DIFF_W-1:0] bx1;
  logic signed [DIFF_W-1:0] cy1;

  logic                     v2;
  logic                     straddle2;
  logic                     dy_pos2;
  logic signed [PROD_W-1:0] lhs2;
  logic signed [PROD_W-1:0] rhs2;

  logic signed [DIFF_W-1:0] xi_s, yi_s, xj_s, yj_s, x_s, y_s;

  assign xi_s = DIFF_W'($signed(req.xi));
  assign yi_s = DIFF_W'($signed(req.yi));
  assign xj_s = DIFF_W'($signed(req.xj));
  assign yj_s = DIFF_W'($signed(req.yj));
  assign x_s  = DIFF_W'($signed(req.x));
  assign y_s  = DIFF_W'($signed(req.y));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
    end
    straddle1 <= (yi_s > y_s) != (yj_s > y_s);
    dy_pos1   <= yj_s > yi_s;
    dy1       <= yj_s - yi_s;
    ax1       <= x_s - xi_s;
    bx1       <= xj_s - xi_s;
    cy1       <= y_s - yi_s;

    straddle2 <= straddle1;
    dy_pos2   <= dy_pos1;
    lhs2      <= PROD_W'(ax1) * PROD_W'(dy1);
    rhs2      <= PROD_W'(bx1) * PROD_W'(cy1);
  end

  always_comb begin
    rsp.valid = v2;
    rsp.hit   = straddle2 && (dy_pos2 ? (lhs2 < rhs2) : (lhs2 > rhs2));
    rsp.busy  = v1 || v2;
  end

endmodule
`default_nettype wire
